// ===== hdl/lsr_pkg.sv =====
`timescale 1ns / 1ps
package lsr_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] row;
    logic [5:0] column;
    logic [1:0] action_kind;
    logic [7:0] argument;
    logic [7:0] rule_index;
    logic [5:0] rule_lhs;
    logic [3:0] rule_len;
    logic [5:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] event_value;
    logic       last;
  } out_item_t;

  // request codes
  localparam logic [1:0] REQ_LOAD_ACT  = 2'd0;
  localparam logic [1:0] REQ_LOAD_RULE = 2'd1;
  localparam logic [1:0] REQ_SYMBOL    = 2'd2;
  localparam logic [1:0] REQ_END       = 2'd3;

  // action kinds
  localparam logic [1:0] ACT_ERROR  = 2'd0;
  localparam logic [1:0] ACT_SHIFT  = 2'd1;
  localparam logic [1:0] ACT_REDUCE = 2'd2;

  // event kinds
  localparam logic [1:0] EV_SHIFT  = 2'd0;
  localparam logic [1:0] EV_REDUCE = 2'd1;
  localparam logic [1:0] EV_ACCEPT = 2'd2;
  localparam logic [1:0] EV_REJECT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_INITIAL = 2'd0;
  localparam logic [1:0] CFG_FINAL   = 2'd1;
  localparam logic [1:0] CFG_SYMCNT  = 2'd2;

  // at most this many reductions per symbol item; a further lookup rejects it
  localparam logic [5:0] RUN_LAST = 6'd63;

  localparam int ENTRY_W = 10;

endpackage

// ===== hdl/lr_shift_reduce_engine.sv =====
`timescale 1ns / 1ps
// Load items write on acceptance; an end item's event shows the cycle after it.
// A symbol item does registered reads: the action table for the shift, and for each
// reduction the action table, rule table, stack and goto entry in turn.
// One item is in work at a time; a waiting output event stalls further emission.
// Reset (rst_n low, synchronous) clears state, stack and config registers and sets
// a one-entry stack of state 0; table memories hold nothing defined until loaded.
module lr_shift_reduce_engine import lsr_pkg::*; #(
  parameter int NUM_STATES  = 256,
  parameter int NUM_SYMBOLS = 64,
  parameter int NUM_RULES   = 256,
  parameter int STACK_DEPTH = 64,
  parameter int MAX_RHS     = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int AW  = $clog2(NUM_STATES * NUM_SYMBOLS);
  localparam int RW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_RULE  = 3'd3;
  localparam logic [2:0] S_BELOW = 3'd4;
  localparam logic [2:0] S_GOTO  = 3'd5;
  localparam logic [2:0] S_REJ   = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt, spn_r, spn_nxt;
  logic [7:0]     top_r, top_nxt, base_r, base_nxt;
  logic           rej_r, rej_nxt;
  logic [5:0]     sym_r, sym_nxt, lhs_r, lhs_nxt;
  logic [5:0]     n_r, n_nxt;
  logic [7:0]     arg_r, arg_nxt;
  logic [7:0]     init_r, init_nxt, fin_r, fin_nxt;
  logic [6:0]     scnt_r, scnt_nxt;
  out_item_t      out_r, out_nxt;
  logic           outv_r, outv_nxt;

  logic               act_we, act_re, rule_we, rule_re, stk_we, stk_re;
  logic [AW-1:0]      act_waddr, act_raddr;
  logic [ENTRY_W-1:0] act_wdata, act_rdata, rule_wdata, rule_rdata;
  logic [RW-1:0]      rule_waddr, rule_raddr;
  logic [SIW-1:0]     stk_waddr, stk_raddr;
  logic [7:0]         stk_wdata, stk_rdata;

  logic       out_free, accept, emit;
  out_item_t  ev;
  logic [1:0] a_kind;
  logic [7:0] a_arg, below;
  logic [5:0] r_lhs;
  logic [3:0] r_len;
  logic [SPW-1:0] spn_m1;

  lsr_tables #(.AW(AW), .RW(RW)) u_tables (
    .clk, .act_we, .act_waddr, .act_wdata, .act_re, .act_raddr, .act_rdata,
    .rule_we, .rule_waddr, .rule_wdata, .rule_re, .rule_raddr, .rule_rdata
  );

  lsr_stack #(.SIW(SIW)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign out_free  = !outv_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  assign a_kind = act_rdata[9:8];
  assign a_arg  = act_rdata[7:0];
  assign r_lhs  = rule_rdata[9:4];
  assign r_len  = rule_rdata[3:0];
  assign spn_m1 = spn_r - SPW'(1);
  // the bottom entry lives in a register, memory slot 0 is never used
  assign below  = (spn_m1 == '0) ? base_r : stk_rdata;

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    spn_nxt   = spn_r;
    top_nxt   = top_r;
    base_nxt  = base_r;
    rej_nxt   = rej_r;
    sym_nxt   = sym_r;
    lhs_nxt   = lhs_r;
    n_nxt     = n_r;
    arg_nxt   = arg_r;
    init_nxt  = init_r;
    fin_nxt   = fin_r;
    scnt_nxt  = scnt_r;
    act_we    = 1'b0;
    act_waddr = AW'(AW'(in_data.row) * AW'(NUM_SYMBOLS) + AW'(in_data.column));
    act_wdata = {(in_data.action_kind == 2'd3) ? ACT_ERROR : in_data.action_kind,
                 in_data.argument};
    act_re    = 1'b0;
    act_raddr = AW'(AW'(top_r) * AW'(NUM_SYMBOLS) + AW'(sym_r));
    rule_we    = 1'b0;
    rule_waddr = RW'(in_data.rule_index);
    rule_wdata = {in_data.rule_lhs, in_data.rule_len};
    rule_re    = 1'b0;
    rule_raddr = RW'(a_arg);
    stk_we    = 1'b0;
    stk_waddr = SIW'(sp_r);
    stk_wdata = a_arg;
    stk_re    = 1'b0;
    stk_raddr = SIW'(spn_nxt - SPW'(1));
    emit      = 1'b0;
    ev        = '{event_kind: EV_REJECT, event_value: 8'd0, last: 1'b1};

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL: init_nxt = cfg_wdata;
        CFG_FINAL:   fin_nxt  = cfg_wdata;
        CFG_SYMCNT:  scnt_nxt = cfg_wdata[6:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.req_type)
            REQ_LOAD_ACT: begin
              act_we = (32'(in_data.row) < NUM_STATES) &&
                       (32'(in_data.column) < NUM_SYMBOLS);
            end
            REQ_LOAD_RULE: begin
              rule_we = (32'(in_data.rule_index) < NUM_RULES) &&
                        (32'(in_data.rule_len) <= MAX_RHS);
            end
            REQ_SYMBOL: begin
              if (!rej_r) begin
                sym_nxt = in_data.symbol;
                n_nxt   = '0;
                if ((32'(in_data.symbol) >= 32'(scnt_r)) ||
                    (32'(in_data.symbol) >= NUM_SYMBOLS)) begin
                  emit    = 1'b1;
                  rej_nxt = 1'b1;
                end else begin
                  state_nxt = S_LOOK;
                end
              end
            end
            REQ_END: begin
              emit = 1'b1;
              ev.event_kind = (!rej_r && top_r == fin_r) ? EV_ACCEPT : EV_REJECT;
              top_nxt  = init_r;
              base_nxt = init_r;
              sp_nxt   = SPW'(1);
              rej_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        if (n_r >= RUN_LAST || 32'(top_r) >= NUM_STATES) begin
          state_nxt = S_REJ;
        end else begin
          act_re    = 1'b1;
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        priority if (a_kind == ACT_SHIFT) begin
          if (32'(sp_r) >= STACK_DEPTH) begin
            state_nxt = S_REJ;
          end else if (out_free) begin
            stk_we = 1'b1;
            top_nxt = a_arg;
            sp_nxt  = sp_r + SPW'(1);
            emit    = 1'b1;
            ev      = '{event_kind: EV_SHIFT, event_value: {2'b00, sym_r}, last: 1'b1};
            state_nxt = S_IDLE;
          end
        end else if (a_kind == ACT_REDUCE) begin
          if (32'(a_arg) >= NUM_RULES) begin
            state_nxt = S_REJ;
          end else begin
            rule_re   = 1'b1;
            arg_nxt   = a_arg;
            state_nxt = S_RULE;
          end
        end else begin
          state_nxt = S_REJ;
        end
      end
      S_RULE: begin
        if (32'(r_len) >= 32'(sp_r)) begin
          state_nxt = S_REJ;
        end else begin
          spn_nxt   = sp_r - SPW'(r_len);
          lhs_nxt   = r_lhs;
          stk_re    = 1'b1;
          stk_raddr = SIW'(spn_nxt - SPW'(1));
          state_nxt = S_BELOW;
        end
      end
      S_BELOW: begin
        if ((32'(lhs_r) >= 32'(scnt_r)) || (32'(lhs_r) >= NUM_SYMBOLS) ||
            (32'(below) >= NUM_STATES) || (32'(spn_r) >= STACK_DEPTH)) begin
          state_nxt = S_REJ;
        end else begin
          act_re    = 1'b1;
          act_raddr = AW'(AW'(below) * AW'(NUM_SYMBOLS) + AW'(lhs_r));
          state_nxt = S_GOTO;
        end
      end
      S_GOTO: begin
        if (out_free) begin
          stk_we    = 1'b1;
          stk_waddr = SIW'(spn_r);
          top_nxt   = a_arg;
          sp_nxt    = spn_r + SPW'(1);
          n_nxt     = n_r + 6'd1;
          emit      = 1'b1;
          ev        = '{event_kind: EV_REDUCE, event_value: arg_r, last: 1'b0};
          state_nxt = S_LOOK;
        end
      end
      S_REJ: begin
        if (out_free) begin
          emit      = 1'b1;
          rej_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_nxt  = out_r;
    outv_nxt = outv_r;
    if (emit) begin
      out_nxt  = ev;
      outv_nxt = 1'b1;
    end else if (outv_r && !out_stall) begin
      outv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= SPW'(1);
      spn_r   <= SPW'(1);
      top_r   <= '0;
      base_r  <= '0;
      rej_r   <= 1'b0;
      n_r     <= '0;
      init_r  <= '0;
      fin_r   <= '0;
      scnt_r  <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      spn_r   <= spn_nxt;
      top_r   <= top_nxt;
      base_r  <= base_nxt;
      rej_r   <= rej_nxt;
      n_r     <= n_nxt;
      init_r  <= init_nxt;
      fin_r   <= fin_nxt;
      scnt_r  <= scnt_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    lhs_r <= lhs_nxt;
    arg_r <= arg_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r != '0) && (32'(sp_r) <= STACK_DEPTH))
    else $error("stack pointer out of range");

  a_rej_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rej_r |-> (state_r == S_IDLE))
    else $error("symbol work while rejected");

  a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GOTO) |-> (n_r < RUN_LAST))
    else $error("event run limit exceeded");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (outv_r && out_stall) |=> (outv_r && $stable(out_r)))
    else $error("pending event overwritten");
`endif

endmodule

// ===== hdl/lsr_tables.sv =====
`timescale 1ns / 1ps
module lsr_tables import lsr_pkg::*; #(
  parameter int AW = 14,
  parameter int RW = 8
) (
  input  logic               clk,
  input  logic               act_we,
  input  logic [AW-1:0]      act_waddr,
  input  logic [ENTRY_W-1:0] act_wdata,
  input  logic               act_re,
  input  logic [AW-1:0]      act_raddr,
  output logic [ENTRY_W-1:0] act_rdata,
  input  logic               rule_we,
  input  logic [RW-1:0]      rule_waddr,
  input  logic [ENTRY_W-1:0] rule_wdata,
  input  logic               rule_re,
  input  logic [RW-1:0]      rule_raddr,
  output logic [ENTRY_W-1:0] rule_rdata
);

  logic [ENTRY_W-1:0] act_mem [2**AW];
  logic [ENTRY_W-1:0] rule_mem [2**RW];

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    if (act_re) begin
      act_rdata <= act_mem[act_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[rule_waddr] <= rule_wdata;
    end
    if (rule_re) begin
      rule_rdata <= rule_mem[rule_raddr];
    end
  end

endmodule

// ===== hdl/lsr_stack.sv =====
`timescale 1ns / 1ps
module lsr_stack #(
  parameter int SIW = 6
) (
  input  logic           clk,
  input  logic           we,
  input  logic [SIW-1:0] waddr,
  input  logic [7:0]     wdata,
  input  logic           re,
  input  logic [SIW-1:0] raddr,
  output logic [7:0]     rdata
);

  logic [7:0] mem [2**SIW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
